### hdl/vgm_pkg.sv
// Package with shared constants for the voxel gradient merge block.
package vgm_pkg;
  localparam int NumDirs = 7;
  localparam int GradBits = 19;
  localparam logic [2:0] ModeSum = 3'd0;
  localparam logic [2:0] ModeMax = 3'd1;
  localparam logic [2:0] ModeAvg = 3'd2;
  localparam logic [2:0] ModeRms = 3'd3;
  localparam logic [2:0] ModeMed = 3'd4;
  localparam logic RegMask = 1'b0;
  localparam logic RegMode = 1'b1;
endpackage

### hdl/vgm_diff.sv
// Stage one: absolute differences of the enabled neighbors against the center, and their count.
module vgm_diff
  import vgm_pkg::*;
#(
  parameter int SB = 16
) (
  input  logic clk,
  input  logic en,
  input  logic signed [SB-1:0] center,
  input  logic signed [SB-1:0] nb [NumDirs],
  input  logic [NumDirs-1:0] mask,
  output logic [SB:0] dabs [NumDirs],
  output logic [2:0] cnt
);
  logic [SB:0] d_next [NumDirs];
  logic [2:0] c_next;

  always_comb begin
    logic signed [SB:0] df;
    c_next = 3'd0;
    for (int i = 0; i < NumDirs; i++) begin
      df = {nb[i][SB-1], nb[i]} - {center[SB-1], center};
      d_next[i] = mask[i] ? (df[SB] ? -df : df) : '0;
      c_next = c_next + {2'b0, mask[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dabs <= d_next;
      cnt <= c_next;
    end
  end
endmodule

### hdl/vgm_merge.sv
// Merge stages: sum, maximum, median, sum of squares, and divide by count.
module vgm_merge
  import vgm_pkg::*;
#(
  parameter int SB = 16
) (
  input  logic clk,
  input  logic [6:1] en,
  input  logic [SB:0] dabs [NumDirs],
  input  logic [2:0] cnt,
  input  logic [2:0] mode,
  output logic [2*SB+4:0] quot,
  output logic [2:0] mode_o,
  output logic [2:0] cnt_o,
  output logic [SB+3:0] passv
);
  localparam int DW = SB + 1;
  localparam int SW = 2 * DW + 3;
  // Stage 2: squares, sum, maximum, median by rank counting.
  logic [2*DW-1:0] sq [NumDirs];
  logic [DW+2:0] sum2, mx2, med2;
  logic [2:0] cnt2, md2;
  logic [DW+2:0] sum_n, mx_n, med_n;

  always_comb begin
    logic [2:0] rk, ks;
    sum_n = '0;
    mx_n = '0;
    med_n = '0;
    for (int i = 0; i < NumDirs; i++) begin
      sum_n = sum_n + {3'b0, dabs[i]};
      if ({3'b0, dabs[i]} > mx_n) mx_n = {3'b0, dabs[i]};
    end
    // Disabled lanes are zero, and sit lowest; the target rank shifts by them.
    ks = 3'(3'd7 - cnt + {1'b0, cnt[2:1]});
    for (int i = 0; i < NumDirs; i++) begin
      rk = '0;
      for (int j = 0; j < NumDirs; j++) begin
        if (dabs[j] < dabs[i] || (dabs[j] == dabs[i] && j < i)) rk = rk + 3'd1;
      end
      if (rk == ks) med_n = {3'b0, dabs[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < NumDirs; i++) sq[i] <= dabs[i] * dabs[i];
      sum2 <= sum_n;
      mx2 <= mx_n;
      med2 <= med_n;
      cnt2 <= cnt;
      md2 <= mode;
    end
  end

  // Stage 3: sum of squares and choice of dividend.
  logic [SW-1:0] num3;
  logic [2:0] cnt3, md3;
  logic [DW+2:0] pv3;
  always_ff @(posedge clk) begin
    logic [SW-1:0] acc;
    if (en[2]) begin
      acc = '0;
      for (int i = 0; i < NumDirs; i++) acc = acc + SW'(sq[i]);
      num3 <= (md2 == ModeRms) ? acc : SW'(sum2);
      pv3 <= (md2 == ModeMax) ? mx2 : (md2 == ModeMed) ? med2 : sum2;
      cnt3 <= cnt2;
      md3 <= md2;
    end
  end

  // Stages 4 to 7: restoring division by the count, about SW/4 bits a stage.
  localparam int DS = 4;
  localparam int BPS = (SW + DS - 1) / DS;
  logic [SW-1:0] qn [DS+1];
  logic [2:0] rm [DS+1];
  logic [2:0] cn [DS+1];
  logic [2:0] mn [DS+1];
  logic [DW+2:0] pn [DS+1];
  assign qn[0] = num3;
  assign rm[0] = '0;
  assign cn[0] = cnt3;
  assign mn[0] = md3;
  assign pn[0] = pv3;
  for (genvar s = 0; s < DS; s++) begin : g_div
    always_ff @(posedge clk) begin
      logic [SW-1:0] q;
      logic [3:0] r;
      if (en[3+s]) begin
        q = qn[s];
        r = {1'b0, rm[s]};
        for (int b = 0; b < BPS; b++) begin
          if (s * BPS + b < SW) begin
            r = {r[2:0], q[SW-1]};
            q = {q[SW-2:0], 1'b0};
            if (cn[s] != 3'd0 && r >= {1'b0, cn[s]}) begin
              r = r - {1'b0, cn[s]};
              q[0] = 1'b1;
            end
          end
        end
        qn[s+1] <= q;
        rm[s+1] <= r[2:0];
        cn[s+1] <= cn[s];
        mn[s+1] <= mn[s];
        pn[s+1] <= pn[s];
      end
    end
  end
  // The quotient bits shift in while the dividend shifts out.
  assign quot = qn[DS];
  assign mode_o = mn[DS];
  assign cnt_o = cn[DS];
  assign passv = pn[DS];
endmodule

### hdl/vgm_sqrt.sv
// Pipelined integer square root with one result bit per stage.
module vgm_sqrt #(
  parameter int SW = 36,
  parameter int RW = 18,
  parameter int PW = 8
) (
  input  logic clk,
  input  logic [RW-1:0] en,
  input  logic [SW-1:0] x,
  input  logic [PW-1:0] pass_in,
  output logic [RW-1:0] root,
  output logic [PW-1:0] pass_out
);
  localparam int XW = 2 * RW;
  logic [XW-1:0] rem [RW+1];
  logic [RW-1:0] rt [RW+1];
  logic [PW-1:0] ps [RW+1];
  assign rem[0] = XW'(x);
  assign rt[0] = '0;
  assign ps[0] = pass_in;
  for (genvar s = 0; s < RW; s++) begin : g_st
    localparam int B = RW - 1 - s;
    always_ff @(posedge clk) begin
      logic [XW-1:0] t;
      if (en[s]) begin
        t = (XW'(rt[s]) << (B + 1)) | (XW'(1) << (2 * B));
        if (rem[s] >= t) begin
          rem[s+1] <= rem[s] - t;
          rt[s+1] <= rt[s] | (RW'(1) << B);
        end else begin
          rem[s+1] <= rem[s];
          rt[s+1] <= rt[s];
        end
        ps[s+1] <= ps[s];
      end
    end
  end
  assign root = rt[RW];
  assign pass_out = ps[RW];
endmodule

### hdl/voxel_gradient_merge_top.sv
// Top level of the voxel gradient merge block.
// One request carries a center voxel and its seven lower neighbors on
// in_valid/in_ready; one result (gradient, empty_set) leaves on
// out_valid/out_ready for each request, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 direction
// mask, 1 merge mode) at once; write only while the block is idle.
// The datapath is a fixed pipeline: differences, squares and order statistics,
// sum of squares, four division stages, SAMPLE_BITS+3 square-root stages, and
// a final saturation stage, the same for every mode. Throughput is one request
// per cycle while the receiver is ready or the pipeline has a gap. When the
// receiver stalls, a stage takes new data only while it or a later stage has
// a gap, so in_ready is low only while the pipeline is full and stalled.
// Reset clears all valid bits and sets the mask to 7 and the mode to sum.
module voxel_gradient_merge_top
  import vgm_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [SAMPLE_BITS-1:0] center_value,
  input  logic [SAMPLE_BITS-1:0] minus_x_value,
  input  logic [SAMPLE_BITS-1:0] minus_y_value,
  input  logic [SAMPLE_BITS-1:0] minus_z_value,
  input  logic [SAMPLE_BITS-1:0] minus_xy_value,
  input  logic [SAMPLE_BITS-1:0] minus_xz_value,
  input  logic [SAMPLE_BITS-1:0] minus_yz_value,
  input  logic [SAMPLE_BITS-1:0] minus_xyz_value,
  output logic out_valid,
  input  logic out_ready,
  output logic [GradBits-1:0] gradient,
  output logic empty_set,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [6:0] cfg_data
);
  localparam int SB = SAMPLE_BITS;
  localparam int SW = 2 * (SB + 1) + 3;
  localparam int RW = (SW + 1) / 2;
  localparam int PW = 3 + 3 + SB + 4;
  localparam int NS = 1 + 6 + RW + 1;

  logic [6:0] mask;
  logic [2:0] mode;
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= 7'd7;
      mode <= ModeSum;
    end else if (cfg_we) begin
      case (cfg_index)
        RegMask: mask <= cfg_data;
        RegMode: mode <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  logic [NS-1:0] vld;
  logic [NS-1:0] en;
  always_comb begin
    logic hole;
    hole = out_ready;
    for (int s = NS - 1; s >= 0; s--) begin
      hole = hole || !vld[s];
      en[s] = hole;
    end
  end
  assign in_ready = en[0];
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else begin
      if (en[0]) vld[0] <= in_valid;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) vld[s] <= vld[s-1];
      end
    end
  end

  logic signed [SB-1:0] nb [NumDirs];
  assign nb[0] = minus_x_value;
  assign nb[1] = minus_y_value;
  assign nb[2] = minus_z_value;
  assign nb[3] = minus_xy_value;
  assign nb[4] = minus_xz_value;
  assign nb[5] = minus_yz_value;
  assign nb[6] = minus_xyz_value;

  logic [SB:0] dabs [NumDirs];
  logic [2:0] cnt1, mode1;
  vgm_diff #(.SB(SB)) u_diff (
    .clk(clk), .en(en[0]), .center(center_value), .nb(nb), .mask(mask),
    .dabs(dabs), .cnt(cnt1)
  );
  always_ff @(posedge clk) if (en[0]) mode1 <= mode;

  logic [SW-1:0] quot;
  logic [2:0] mode_m, cnt_m;
  logic [SB+3:0] pv_m;
  vgm_merge #(.SB(SB)) u_merge (
    .clk(clk), .en(en[6:1]), .dabs(dabs), .cnt(cnt1), .mode(mode1),
    .quot(quot), .mode_o(mode_m), .cnt_o(cnt_m), .passv(pv_m)
  );

  logic [RW-1:0] root;
  logic [PW-1:0] pin, pout;
  logic [SB+3:0] qlow;
  assign qlow = quot[SB+3:0];
  assign pin = {mode_m, cnt_m, (mode_m == ModeAvg) ? qlow : pv_m};
  vgm_sqrt #(.SW(SW), .RW(RW), .PW(PW)) u_sqrt (
    .clk(clk), .en(en[7+RW-1:7]), .x(quot), .pass_in(pin),
    .root(root), .pass_out(pout)
  );

  logic [2:0] mf, cf;
  logic [SB+3:0] vf;
  logic [RW+SB+3:0] g;
  assign {mf, cf, vf} = pout;
  always_comb begin
    case (mf)
      ModeSum, ModeMax, ModeAvg, ModeMed: g = (RW+SB+4)'(vf);
      ModeRms: g = (RW+SB+4)'(root);
      default: g = '0;
    endcase
  end
  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      empty_set <= (cf == 3'd0);
      if (cf == 3'd0) gradient <= '0;
      else if (g > (RW+SB+4)'({GradBits{1'b1}})) gradient <= '1;
      else gradient <= g[GradBits-1:0];
    end
  end
  assign out_valid = vld[NS-1];
endmodule
